@@ rtl/abae_pkg.sv @@
// ----------------------------------------------------------------------------
// abae_pkg
// Shared types and constants of the adaptive binary arithmetic encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package abae_pkg;

  localparam int unsigned CODE_WIDTH_DEF = 32;
  localparam int unsigned PROB_W         = 33;
  localparam int unsigned FOL_W          = 32;
  localparam int unsigned ONES_W         = 17;
  localparam int unsigned MAX_RES        = 33;
  localparam int unsigned DIG_W          = 8;
  localparam int unsigned MUL_DIGITS     = 5;
  localparam int unsigned MUL_W          = DIG_W * MUL_DIGITS;
  localparam int unsigned FRAC_W         = 32;

  typedef struct packed {
    logic              bit_value;
    logic              first_bit;
    logic [PROB_W-1:0] start_prob;
    logic [PROB_W-1:0] one_factor;
    logic              last_bit;
  } in_item_t;

  typedef struct packed {
    logic              code_bit;
    logic [FOL_W-1:0]  follow_count;
    logic              block_end;
    logic [ONES_W-1:0] ones_count;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/abae_front.sv @@
// ----------------------------------------------------------------------------
// abae_front
// Input side: takes transactions and holds them in a two-entry queue for the
// coding core.
// ----------------------------------------------------------------------------
`default_nettype none

module abae_front import abae_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          cmd_valid_o,
  output in_item_t      cmd_o,
  input  wire logic     cmd_pop_i
);

  in_item_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      unique case ({push, cmd_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/abae_core.sv @@
// ----------------------------------------------------------------------------
// abae_core
// Coding core: shift-add interval and probability products, interval update,
// one renormalisation shift per cycle (an emitting shift waits while the output is stalled) and the block flush.
// ----------------------------------------------------------------------------
`default_nettype none

module abae_core import abae_pkg::*; #(
  parameter int unsigned CodeWidth = CODE_WIDTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire in_item_t  cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  output out_item_t      out_data_o,
  input  wire logic      out_stall_i,
  output logic           busy_o
);

  localparam int unsigned WW  = CodeWidth + 1;
  localparam int unsigned AW1 = WW + MUL_W;
  localparam int unsigned AW2 = PROB_W + MUL_W;
  localparam int unsigned SW  = AW1 - FRAC_W;
  localparam int unsigned PW  = AW2 - FRAC_W;
  localparam int unsigned IW  = $clog2(CodeWidth + 1);
  localparam int unsigned NW  = $clog2(MAX_RES + 1);
  localparam int unsigned CW3 = $clog2(MUL_DIGITS);

  localparam logic [CodeWidth-1:0] CMask  = {CodeWidth{1'b1}};
  localparam logic [CodeWidth-1:0] CQuar  = {2'b01, {(CodeWidth-2){1'b0}}};
  localparam logic [CodeWidth-1:0] C3Quar = {2'b11, {(CodeWidth-2){1'b0}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_UPD, S_RENORM, S_FLUSH} state_e;

  state_e                 state_q;
  logic [CodeWidth-1:0]   low_q, high_q;
  logic [FOL_W-1:0]       pf_q;
  logic [PROB_W-1:0]      prob_q;
  logic [ONES_W-1:0]      ones_q;
  logic                   bit_q, last_q;
  logic [MUL_W-1:0]       f1_q, f2_q;
  logic [AW1-1:0]         acc1_q;
  logic [AW2-1:0]         acc2_q;
  logic [CW3-1:0]         cnt_q;
  logic [IW-1:0]          iter_q;
  logic [NW-1:0]          n_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic [WW-1:0]          width;
  logic [WW+DIG_W-1:0]    pp1;
  logic [PROB_W+DIG_W-1:0] pp2;
  logic [AW1-1:0]         acc1_d;
  logic [AW2-1:0]         acc2_d;
  logic [SW-1:0]          sub_raw;
  logic [CodeWidth-1:0]   sub_c;
  logic [PW-1:0]          p_raw;
  logic [PROB_W-1:0]      prob_new;
  logic                   e1, e2, e3, out_free, can_put;
  logic                   out_load;
  logic [FOL_W-1:0]       pf_inc;

  assign width  = {1'b0, high_q - low_q} + WW'(1);
  assign pp1    = width * f1_q[MUL_W-1 -: DIG_W];
  assign pp2    = prob_q * f2_q[MUL_W-1 -: DIG_W];
  assign acc1_d = {acc1_q[AW1-DIG_W-1:0], {DIG_W{1'b0}}} + AW1'(pp1);
  assign acc2_d = {acc2_q[AW2-DIG_W-1:0], {DIG_W{1'b0}}} + AW2'(pp2);

  assign sub_raw = acc1_q[AW1-1:FRAC_W];
  assign p_raw   = acc2_q[AW2-1:FRAC_W];

  always_comb begin
    if (|sub_raw[SW-1:CodeWidth]) begin
      sub_c = CMask;
    end else if (sub_raw[CodeWidth-1:0] == '0) begin
      sub_c = CodeWidth'(1);
    end else begin
      sub_c = sub_raw[CodeWidth-1:0];
    end
  end

  assign prob_new = (|p_raw[PW-1:PROB_W]) ? {PROB_W{1'b1}} : p_raw[PROB_W-1:0];

  assign e1       = !high_q[CodeWidth-1];
  assign e2       = low_q[CodeWidth-1];
  assign e3       = (low_q >= CQuar) && (high_q < C3Quar);
  assign out_free = !out_valid_q || !out_stall_i;
  assign can_put  = (n_q < NW'(MAX_RES));
  assign pf_inc   = (pf_q == {FOL_W{1'b1}}) ? pf_q : pf_q + FOL_W'(1);

  // a result register load: an emitting shift or the flush
  assign out_load = out_free && can_put &&
                    ((state_q == S_FLUSH) ||
                     ((state_q == S_RENORM) && (iter_q != IW'(CodeWidth)) && (e1 || e2)));

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign busy_o      = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      low_q       <= '0;
      high_q      <= CMask;
      pf_q        <= '0;
      prob_q      <= '0;
      ones_q      <= '0;
      bit_q       <= 1'b0;
      last_q      <= 1'b0;
      f1_q        <= '0;
      f2_q        <= '0;
      acc1_q      <= '0;
      acc2_q      <= '0;
      cnt_q       <= '0;
      iter_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.first_bit) begin
              low_q  <= '0;
              high_q <= CMask;
              pf_q   <= '0;
              ones_q <= '0;
              prob_q <= cmd_i.start_prob;
              f1_q   <= MUL_W'(cmd_i.start_prob);
            end else begin
              f1_q   <= MUL_W'(prob_q);
            end
            f2_q    <= MUL_W'(cmd_i.one_factor);
            bit_q   <= cmd_i.bit_value;
            last_q  <= cmd_i.last_bit;
            acc1_q  <= '0;
            acc2_q  <= '0;
            cnt_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          acc1_q <= acc1_d;
          acc2_q <= acc2_d;
          f1_q   <= f1_q << DIG_W;
          f2_q   <= f2_q << DIG_W;
          cnt_q  <= cnt_q + CW3'(1);
          if (cnt_q == CW3'(MUL_DIGITS - 1)) state_q <= S_UPD;
        end
        S_UPD: begin
          if (bit_q) begin
            low_q  <= low_q + sub_c;
            prob_q <= prob_new;
            if (ones_q != {ONES_W{1'b1}}) ones_q <= ones_q + ONES_W'(1);
          end else begin
            high_q <= low_q + sub_c - CodeWidth'(1);
          end
          iter_q  <= '0;
          n_q     <= '0;
          state_q <= S_RENORM;
        end
        S_RENORM: begin
          if (iter_q == IW'(CodeWidth) || !(e1 || e2 || e3)) begin
            state_q <= last_q ? S_FLUSH : S_IDLE;
          end else if (e1 || e2) begin
            if (out_free) begin
              // results beyond the limit are dropped, the interval still moves
              if (can_put) begin
                out_q.code_bit     <= !e1;
                out_q.follow_count <= pf_q;
                out_q.block_end    <= 1'b0;
                out_q.ones_count   <= '0;
                n_q                <= n_q + NW'(1);
              end
              pf_q   <= '0;
              low_q  <= low_q << 1;
              high_q <= {high_q[CodeWidth-2:0], 1'b1};
              iter_q <= iter_q + IW'(1);
            end
          end else begin
            pf_q   <= pf_inc;
            low_q  <= (low_q - CQuar) << 1;
            high_q <= {high_q[CodeWidth-2:0] - CQuar[CodeWidth-2:0], 1'b1};
            iter_q <= iter_q + IW'(1);
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            if (can_put) begin
              out_q.code_bit     <= (low_q >= CQuar);
              out_q.follow_count <= pf_inc;
              out_q.block_end    <= 1'b1;
              out_q.ones_count   <= ones_q;
            end
            pf_q    <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/adaptive_binary_arith_encoder.sv @@
// ----------------------------------------------------------------------------
// adaptive_binary_arith_encoder
// Adaptive binary arithmetic encoder with follow-bit counting and block flush.
// ----------------------------------------------------------------------------
// flow: the two-entry queue, then the core: idle, the shift-add multiplier (8 bits a
//   cycle), update, renormalisation shifts (0..CodeWidth, one per cycle, an emitting
//   shift waiting while the output is stalled) and a flush on the last bit; the core
//   takes a new transaction only from idle
// reset: interval low 0, high all ones, follow, probability and ones cleared
`default_nettype none

module adaptive_binary_arith_encoder import abae_pkg::*; #(
  parameter int unsigned CodeWidth = CODE_WIDTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic     cmd_valid, cmd_pop, core_busy;
  in_item_t cmd;

  abae_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  abae_core #(.CodeWidth(CodeWidth)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .busy_o      (core_busy)
  );

  // ones are only reported on the closing transaction of a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.block_end |-> out_data_o.ones_count == '0)
    else $error("ones count set on a non-final result");

  // a new result only appears while the core is working on an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(core_busy))
    else $error("result produced by an idle core");

  // the core only takes a queued item when it is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid && !core_busy)
    else $error("queue popped while core busy or empty");

endmodule

`default_nettype wire

@@ dv/abae_checker.sv @@
// ----------------------------------------------------------------------------
// abae_checker
// Watches both channels of the encoder, models the coder per transaction and
// compares every emitted code bit against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abae_checker import abae_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_item_t out_data_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             bits_seen_o,
  output int             blocks_seen_o
);

  localparam logic [31:0] HALF = 32'h8000_0000;
  localparam logic [31:0] QUAR = 32'h4000_0000;
  localparam logic [31:0] TQUAR = 32'hC000_0000;
  localparam logic [32:0] PROB_MAX = {PROB_W{1'b1}};
  localparam logic [ONES_W-1:0] ONES_MAX = {ONES_W{1'b1}};

  logic [31:0] lo_q, hi_q, fol_q;
  logic [32:0] prob_q;
  logic [ONES_W-1:0] ones_q;
  out_item_t code_queue[$];

  // floor(a * f / 2^32)
  function automatic logic [65:0] scale(input logic [32:0] a, input logic [32:0] f);
    logic [65:0] prod;
    prod = {33'd0, a} * {33'd0, f};
    return prod >> 32;
  endfunction

  task automatic emit(input logic b, input logic [31:0] fol, input logic last,
                      input logic [ONES_W-1:0] ones);
    out_item_t r;
    r.code_bit = b;
    r.follow_count = fol;
    r.block_end = last;
    r.ones_count = ones;
    code_queue.push_back(r);
  endtask

  task automatic encode_bit(input in_item_t it);
    logic [32:0] width;
    logic [65:0] sub, p;
    if (it.first_bit) begin
      lo_q = '0;
      hi_q = '1;
      fol_q = '0;
      ones_q = '0;
      prob_q = it.start_prob;
    end
    width = {1'b0, hi_q - lo_q} + 33'd1;
    sub = scale(width, prob_q);
    if (sub > 66'hFFFF_FFFF) sub = 66'hFFFF_FFFF;
    if (sub == 0) sub = 1;
    if (it.bit_value) begin
      lo_q = lo_q + sub[31:0];
      p = scale(prob_q, it.one_factor);
      prob_q = (p > PROB_MAX) ? PROB_MAX : p[32:0];
      if (ones_q != ONES_MAX) ones_q++;
    end else begin
      hi_q = lo_q + sub[31:0] - 32'd1;
    end
    for (int i = 0; i < 32; i++) begin
      if (hi_q < HALF) begin
        emit(1'b0, fol_q, 1'b0, '0);
        fol_q = 0;
      end else if (lo_q >= HALF) begin
        emit(1'b1, fol_q, 1'b0, '0);
        fol_q = 0;
      end else if (lo_q >= QUAR && hi_q < TQUAR) begin
        if (fol_q != 32'hFFFF_FFFF) fol_q++;
        lo_q -= QUAR;
        hi_q -= QUAR;
      end else begin
        break;
      end
      lo_q = lo_q << 1;
      hi_q = (hi_q << 1) | 32'd1;
    end
    if (it.last_bit) begin
      if (fol_q != 32'hFFFF_FFFF) fol_q++;
      emit(lo_q >= QUAR, fol_q, 1'b1, ones_q);
      fol_q = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      lo_q = '0;
      hi_q = '1;
      fol_q = '0;
      prob_q = '0;
      ones_q = '0;
      code_queue.delete();
      fail_count_o <= 0;
      bits_seen_o <= 0;
      blocks_seen_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        bits_seen_o <= bits_seen_o + 1;
        if (out_data_i.block_end) blocks_seen_o <= blocks_seen_o + 1;
        if (code_queue.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected code bit %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = code_queue.pop_front();
          if (exp_r !== out_data_i) begin
            if (fail_count_o < 10)
              $display("code bit mismatch: expected %p, got %p", exp_r, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // predict after popping so a same-edge output is never matched early
      if (in_valid_i && !in_stall_i) encode_bit(in_data_i);
    end
  end

  assign pending_o = code_queue.size();

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random blocks of bits with varied probabilities and factors into the
// encoder under random gaps and back-pressure, then reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import abae_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [32:0] ONE_P = 33'h1_0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic hold_off = 1'b0;
  logic stim_done = 1'b0;
  int fail_count, pending, bits_seen, blocks_seen, idle_cycles;

  always #1 clk_i = ~clk_i;

  adaptive_binary_arith_encoder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  abae_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending),
    .bits_seen_o(bits_seen), .blocks_seen_o(blocks_seen)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [32:0] rand_prob();
    unique case ($urandom_range(0, 7))
      0: return 33'd0;
      1: return ONE_P;
      2: return 33'({$urandom, $urandom});
      3: return 33'd1;
      default: return {1'b0, $urandom};
    endcase
  endfunction

  task automatic send(input logic b, input logic first, input logic [32:0] sp,
                      input logic [32:0] fac, input logic last);
    int g;
    g = gap_len();
    repeat (g) @(posedge clk_i) in_valid <= 1'b0;
    @(posedge clk_i);
    in_valid <= 1'b1;
    in_data <= '{bit_value: b, first_bit: first, start_prob: sp,
                 one_factor: fac, last_bit: last};
    do @(posedge clk_i); while (in_stall);
    in_valid <= 1'b0;
  endtask

  // receiver stalls; a long hold-off fills the encoder
  always @(posedge clk_i) begin
    if (hold_off || stim_done) out_stall <= hold_off;
    else out_stall <= ($urandom_range(0, 99) < 30);
  end

  initial begin
    @(posedge clk_i);
    wait (bits_seen > 20);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d code bits outstanding", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int len;
    logic [32:0] fac;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes of probability and factor, continuation after flush
    send(1'b0, 1'b1, 33'd0, 33'd0, 1'b0);
    send(1'b1, 1'b0, '1, '1, 1'b0);
    send(1'b1, 1'b0, '1, '1, 1'b1);
    send(1'b1, 1'b0, 33'd0, ONE_P, 1'b0);
    send(1'b0, 1'b0, 33'd0, ONE_P, 1'b1);
    send(1'b1, 1'b1, ONE_P, '1, 1'b0);
    send(1'b1, 1'b0, '0, '1, 1'b0);
    send(1'b0, 1'b0, '0, '1, 1'b1);
    send(1'b1, 1'b1, '1, 33'd0, 1'b1);
    send(1'b0, 1'b1, 33'h0_8000_0000, ONE_P, 1'b0);
    send(1'b1, 1'b0, '0, 33'h0_8000_0000, 1'b0);
    send(1'b0, 1'b0, '0, 33'h0_8000_0000, 1'b0);
    send(1'b1, 1'b0, '0, 33'h0_8000_0000, 1'b1);
    send(1'b1, 1'b1, 33'd1, 33'd1, 1'b1);
    send(1'b0, 1'b1, 33'h0_FFFF_FFFF, 33'h0_FFFF_FFFF, 1'b1);
    send(1'b0, 1'b1, 33'h0_4000_0000, ONE_P, 1'b0);
    for (int i = 0; i < 6; i++)
      send(i[0], 1'b0, 33'h0, 33'h0_C000_0000, i == 5);
    // random blocks, mostly well formed, some starting mid-state
    for (int n = 0; n < 155; n += len) begin
      len = $urandom_range(1, 12);
      fac = rand_prob();
      for (int i = 0; i < len; i++)
        send(1'($urandom_range(0, 1)), (i == 0) && ($urandom_range(0, 9) != 0),
             rand_prob(), ($urandom_range(0, 5) == 0) ? rand_prob() : fac,
             (i == len - 1) && ($urandom_range(0, 9) != 0));
    end
    send(1'b0, 1'b0, '0, '0, 1'b1);
    stim_done = 1'b1;
    wait (pending == 0 && !hold_off);
    repeat (60) @(posedge clk_i);
    $display("covered %0d code bits over %0d flushed blocks", bits_seen, blocks_seen);
    $display("probability and factor extremes, follow runs and a long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ adaptive_binary_arith_encoder.f @@
rtl/abae_pkg.sv
rtl/abae_front.sv
rtl/abae_core.sv
rtl/adaptive_binary_arith_encoder.sv
dv/abae_checker.sv
dv/testbench.sv
